// ----- sv/crx_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crx_pkg: shared types and constants of the COBS packet receiver
// Request payloads, the front-to-back token, result kinds and the
// receiver phases.
// ----------------------------------------------------------------------------
package crx_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W = 9;
    localparam int ADDR_W = 32;
    localparam int ADDR_BYTES = 4;
    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;

    typedef enum logic [2:0] {
        K_CMD       = 3'd0,
        K_IDX       = 3'd1,
        K_PAY       = 3'd2,
        K_END       = 3'd3,
        K_BADADDR   = 3'd4,
        K_OVERRUN   = 3'd5,
        K_MALFORMED = 3'd6
    } t_crx_kind;

    typedef enum logic [2:0] {
        PH_DEST = 3'd0,
        PH_CMD  = 3'd1,
        PH_IDX  = 3'd2,
        PH_PAY  = 3'd3,
        PH_SKIP = 3'd4
    } t_crx_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              host_holding;
    } t_crx_in;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              host_holding;
        logic              is_delim;
        logic              is_max;
    } t_crx_tok;

    typedef struct packed {
        t_crx_kind         kind;
        logic [BYTE_W-1:0] value;
        logic [LEN_W-1:0]  pay_len;
    } t_crx_result;

endpackage
`default_nettype wire

// ----- sv/crx_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crx_fifo: two-entry queue
// Holds up to two entries in registers; a push and a pop may share a cycle.
// ----------------------------------------------------------------------------
module crx_fifo #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_wdata,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_rdata,
    output logic              o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wptr;
    logic         r_rptr;
    logic [1:0]   r_count;
    logic         do_push;
    logic         do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue occupancy out of range");

    a_ptr_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wptr == r_rptr))
        else $error("queue pointers disagree with occupancy");
`endif

endmodule
`default_nettype wire

// ----- sv/crx_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crx_front: receive front end
// Accepts line bytes, marks delimiters and code 255, and queues them as
// tokens for the decoder.
// ----------------------------------------------------------------------------
module crx_front
    import crx_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_crx_in i_item,
    output logic         o_full,
    input  wire logic    i_tok_pop,
    output t_crx_tok     o_tok,
    output logic         o_tok_valid
);

    t_crx_tok tok_in;
    logic     tok_empty;

    always_comb begin
        tok_in.rx_byte      = i_item.rx_byte;
        tok_in.host_holding = i_item.host_holding;
        tok_in.is_delim     = (i_item.rx_byte == '0);
        tok_in.is_max       = (i_item.rx_byte == BYTE_MAX);
    end

    crx_fifo #(
        .W ($bits(t_crx_tok))
    ) u_tok_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_wdata (tok_in),
        .o_full  (o_full),
        .i_pop   (i_tok_pop),
        .o_rdata (o_tok),
        .o_empty (tok_empty)
    );

    assign o_tok_valid = !tok_empty;

endmodule
`default_nettype wire

// ----- sv/crx_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crx_back: COBS decoder and frame sequencer
// Decodes one token a cycle while the result queue has room, checks the destination and emits results.
// ----------------------------------------------------------------------------
module crx_back
    import crx_pkg::*;
#(
    parameter int DEST_BYTES  = 4,
    parameter int PAYLOAD_MAX = 256,
    parameter int CRC_BYTES   = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [ADDR_W-1:0] i_cfg_wdata,
    input  wire t_crx_tok          i_tok,
    input  wire logic              i_tok_valid,
    output logic                   o_tok_pop,
    input  wire logic              i_res_full,
    output logic                   o_res_push,
    output t_crx_result            o_res
);

    localparam int CW = $clog2(DEST_BYTES + 1);
    localparam int PAY_LIMIT = PAYLOAD_MAX + CRC_BYTES;
    localparam int PW = $clog2(PAY_LIMIT + 1);
    localparam int LW = (PW > LEN_W) ? PW : LEN_W;
    localparam logic [ADDR_W-1:0] DEST_MASK = (DEST_BYTES >= ADDR_BYTES) ? '1
        : ADDR_W'((64'd1 << (8 * DEST_BYTES)) - 64'd1);

    t_crx_phase        r_phase, n_phase;
    logic [BYTE_W-1:0] r_block_rem, n_block_rem;
    logic              r_zero_due, n_zero_due;
    logic [CW-1:0]     r_dest_count, n_dest_count;
    logic [ADDR_W-1:0] r_dest_shift, n_dest_shift;
    logic              r_dest_excess, n_dest_excess;
    logic [PW-1:0]     r_payload_count, n_payload_count;
    logic [ADDR_W-1:0] r_own_address;

    logic              dec_ok;
    logic [BYTE_W-1:0] dec_byte;
    logic [BYTE_W-1:0] dec_block;
    logic              dec_zero_due;
    logic [LW-1:0]     len_full;

    assign o_tok_pop = i_tok_valid && !i_res_full;
    assign len_full  = LW'(r_payload_count) - LW'(CRC_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= '0;
        end else if (i_cfg_we) begin
            r_own_address <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_DEST;
            r_block_rem     <= '0;
            r_zero_due      <= 1'b0;
            r_dest_count    <= '0;
            r_dest_shift    <= '0;
            r_dest_excess   <= 1'b0;
            r_payload_count <= '0;
        end else begin
            r_phase         <= n_phase;
            r_block_rem     <= n_block_rem;
            r_zero_due      <= n_zero_due;
            r_dest_count    <= n_dest_count;
            r_dest_shift    <= n_dest_shift;
            r_dest_excess   <= n_dest_excess;
            r_payload_count <= n_payload_count;
        end
    end

    // One COBS step: a code byte opens a block, a data byte passes through.
    always_comb begin
        if (r_block_rem == '0) begin
            dec_ok       = r_zero_due;
            dec_byte     = '0;
            dec_block    = i_tok.rx_byte - 8'd1;
            dec_zero_due = !i_tok.is_max;
        end else begin
            dec_ok       = 1'b1;
            dec_byte     = i_tok.rx_byte;
            dec_block    = r_block_rem - 8'd1;
            dec_zero_due = r_zero_due;
        end
    end

    always_comb begin
        n_phase         = r_phase;
        n_block_rem     = r_block_rem;
        n_zero_due      = r_zero_due;
        n_dest_count    = r_dest_count;
        n_dest_shift    = r_dest_shift;
        n_dest_excess   = r_dest_excess;
        n_payload_count = r_payload_count;
        o_res_push            = 1'b0;
        o_res.kind            = K_CMD;
        o_res.value           = '0;
        o_res.pay_len         = '0;

        if (o_tok_pop) begin
            if (i_tok.is_delim) begin
                n_phase       = PH_DEST;
                n_block_rem   = '0;
                n_zero_due    = 1'b0;
                n_dest_count  = '0;
                n_dest_shift  = '0;
                n_dest_excess = 1'b0;
                unique case (r_phase)
                    PH_CMD, PH_IDX: begin
                        o_res_push = 1'b1;
                        o_res.kind = K_MALFORMED;
                    end
                    PH_PAY: begin
                        o_res_push = 1'b1;
                        if (32'(r_payload_count) < 32'(CRC_BYTES)) begin
                            o_res.kind = K_MALFORMED;
                        end else begin
                            o_res.kind    = K_END;
                            o_res.pay_len = len_full[LEN_W-1:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end else begin
                if (r_phase != PH_SKIP) begin
                    n_block_rem = dec_block;
                    n_zero_due  = dec_zero_due;
                end
                unique case (r_phase)
                    PH_DEST: begin
                        if (dec_ok) begin
                            if (32'(r_dest_count) < 32'(ADDR_BYTES)) begin
                                n_dest_shift = r_dest_shift
                                    | (ADDR_W'(dec_byte) << {r_dest_count, 3'b000});
                            end else if (dec_byte != '0) begin
                                n_dest_excess = 1'b1;
                            end
                            n_dest_count = r_dest_count + CW'(1);
                        end
                        if (32'(n_dest_count) >= 32'(DEST_BYTES)) begin
                            if (n_dest_excess
                                || n_dest_shift != (r_own_address & DEST_MASK)) begin
                                n_phase    = PH_SKIP;
                                o_res_push = 1'b1;
                                o_res.kind = K_BADADDR;
                            end else if (i_tok.host_holding) begin
                                n_phase    = PH_SKIP;
                                o_res_push = 1'b1;
                                o_res.kind = K_OVERRUN;
                            end else begin
                                n_phase = PH_CMD;
                            end
                        end
                    end
                    PH_CMD: begin
                        if (dec_ok) begin
                            n_phase     = PH_IDX;
                            o_res_push  = 1'b1;
                            o_res.kind  = K_CMD;
                            o_res.value = dec_byte;
                        end
                    end
                    PH_IDX: begin
                        if (dec_ok) begin
                            n_phase         = PH_PAY;
                            n_payload_count = '0;
                            o_res_push      = 1'b1;
                            o_res.kind      = K_IDX;
                            o_res.value     = dec_byte;
                        end
                    end
                    PH_PAY: begin
                        if (dec_ok) begin
                            o_res_push = 1'b1;
                            if (32'(r_payload_count) < 32'(PAY_LIMIT)) begin
                                n_payload_count = r_payload_count + PW'(1);
                                o_res.kind      = K_PAY;
                                o_res.value     = dec_byte;
                            end else begin
                                n_phase    = PH_SKIP;
                                o_res.kind = K_MALFORMED;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

`ifndef ASSERT_OFF
    a_delim_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok_pop && i_tok.is_delim) |=> (r_phase == PH_DEST && r_dest_count == '0))
        else $error("delimiter did not restart the frame");

    a_result_needs_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> (o_tok_pop && !i_res_full))
        else $error("result produced without a consumed token");

    a_payload_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_payload_count) <= 32'(PAY_LIMIT))
        else $error("payload count beyond limit");
`endif

endmodule
`default_nettype wire

// ----- sv/cobs_packet_receiver_top.sv -----
`default_nettype none
// A byte request is registered in the token queue; the decoder then writes
// its result, if it gives one, into the result queue, which presents it on
// the result ports.
// Throughput: one byte per cycle while the result queue has room.
// Reset (synchronous, active low) empties both queues, clears the address and
// puts the decoder into the destination phase with all counters at zero.
// ----------------------------------------------------------------------------
// cobs_packet_receiver_top: COBS deframer with destination filter
// Decodes raw line bytes into command, index, payload and frame-status
// results; a frame for another address gives at most a refusal result.
// ----------------------------------------------------------------------------
module cobs_packet_receiver_top
    import crx_pkg::*;
#(
    parameter int DEST_BYTES  = 4,
    parameter int PAYLOAD_MAX = 256,
    parameter int CRC_BYTES   = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [ADDR_W-1:0] i_cfg_wdata,
    input  wire logic              push,
    input  wire t_crx_in           i_rx_item,
    output logic                   full,
    output logic                   empty,
    input  wire logic              pop,
    output t_crx_result            o_result
);

    // The front end classifies each byte request (delimiter, code 255) and
    // holds it in a two-entry queue, so the line side can go on pushing while the
    // decoder waits on a full result queue, until this queue fills as well.
    t_crx_tok    tok;
    logic        tok_valid;
    logic        tok_pop;

    // The back end decodes one token per cycle whenever the result queue has
    // room; a token that yields no result is simply consumed.
    t_crx_result res;
    logic        res_push;
    logic        res_full;

    crx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_rx_item),
        .o_full      (full),
        .i_tok_pop   (tok_pop),
        .o_tok       (tok),
        .o_tok_valid (tok_valid)
    );

    crx_back #(
        .DEST_BYTES  (DEST_BYTES),
        .PAYLOAD_MAX (PAYLOAD_MAX),
        .CRC_BYTES   (CRC_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tok       (tok),
        .i_tok_valid (tok_valid),
        .o_tok_pop   (tok_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    // The result queue separates the decoder from the consumer: the oldest
    // result is presented whenever the queue is not empty.
    crx_fifo #(
        .W ($bits(t_crx_result))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (o_result),
        .o_empty (empty)
    );

endmodule
`default_nettype wire

// ----- tb/crx_checker.sv -----
// ----------------------------------------------------------------------------
// crx_checker: result checker for the COBS packet receiver
// Watches the byte, result and address-write channels, keeps its own copy
// of the deframer state, works out the result, if any, that each accepted request
// should give and compares every popped result with the oldest one waiting.
// ----------------------------------------------------------------------------
module crx_checker
    import crx_pkg::*;
#(
    parameter int DEST_BYTES  = 4,
    parameter int PAYLOAD_MAX = 256,
    parameter int CRC_BYTES   = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [ADDR_W-1:0] i_cfg_wdata,
    input  wire logic              i_push,
    input  wire logic              i_full,
    input  wire t_crx_in           i_rx_item,
    input  wire logic              i_pop,
    input  wire logic              i_empty,
    input  wire t_crx_result       i_result,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked,
    output int                     o_frame_ends,
    output int                     o_rejected,
    output int                     o_malformed
);

    t_crx_phase        rx_phase;
    logic [BYTE_W-1:0] blk_left;
    bit                zero_pending;
    int                dest_seen;
    logic [ADDR_W-1:0] dest_acc;
    bit                dest_extra;
    int                pay_seen;
    logic [ADDR_W-1:0] station_addr;

    t_crx_result       due_results[$];

    function automatic void frame_restart();
        rx_phase     = PH_DEST;
        blk_left     = '0;
        zero_pending = 1'b0;
        dest_seen    = 0;
        dest_acc     = '0;
        dest_extra   = 1'b0;
    endfunction

    // One step of the COBS decoder; returns 1 when a plain byte comes out.
    function automatic bit cobs_step(input logic [BYTE_W-1:0] code_in,
                                     output logic [BYTE_W-1:0] plain);
        bit made;
        if (blk_left == '0) begin
            made         = zero_pending;
            blk_left     = code_in - 8'd1;
            zero_pending = (code_in != BYTE_MAX);
            plain        = '0;
        end else begin
            made     = 1'b1;
            blk_left = blk_left - 8'd1;
            plain    = code_in;
        end
        return made;
    endfunction

    function automatic bit decode_request(input t_crx_in req, output t_crx_result res);
        logic [BYTE_W-1:0] plain;
        logic [ADDR_W-1:0] mask;
        int                cnt;
        res = '0;
        case (rx_phase)
            PH_DEST: begin
                if (req.rx_byte == '0) begin
                    frame_restart();
                    return 1'b0;
                end
                if (cobs_step(req.rx_byte, plain)) begin
                    if (dest_seen < ADDR_BYTES)
                        dest_acc = dest_acc | ({24'd0, plain} << (8 * dest_seen));
                    else if (plain != '0)
                        dest_extra = 1'b1;
                    dest_seen++;
                end
                if (dest_seen >= DEST_BYTES) begin
                    mask = (DEST_BYTES >= ADDR_BYTES) ? '1
                         : ((32'd1 << (8 * DEST_BYTES)) - 32'd1);
                    if (dest_extra || dest_acc != (station_addr & mask)) begin
                        rx_phase = PH_SKIP;
                        res.kind = K_BADADDR;
                        return 1'b1;
                    end
                    if (req.host_holding) begin
                        rx_phase = PH_SKIP;
                        res.kind = K_OVERRUN;
                        return 1'b1;
                    end
                    rx_phase = PH_CMD;
                end
                return 1'b0;
            end
            PH_CMD, PH_IDX: begin
                if (req.rx_byte == '0) begin
                    frame_restart();
                    res.kind = K_MALFORMED;
                    return 1'b1;
                end
                if (cobs_step(req.rx_byte, plain)) begin
                    res.value = plain;
                    if (rx_phase == PH_CMD) begin
                        rx_phase = PH_IDX;
                        res.kind = K_CMD;
                    end else begin
                        rx_phase = PH_PAY;
                        pay_seen = 0;
                        res.kind = K_IDX;
                    end
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_PAY: begin
                if (req.rx_byte == '0) begin
                    cnt = pay_seen;
                    frame_restart();
                    if (cnt < CRC_BYTES) begin
                        res.kind = K_MALFORMED;
                    end else begin
                        res.kind    = K_END;
                        res.pay_len = 9'(cnt - CRC_BYTES);
                    end
                    return 1'b1;
                end
                if (cobs_step(req.rx_byte, plain)) begin
                    if (pay_seen < PAYLOAD_MAX + CRC_BYTES) begin
                        pay_seen++;
                        res.kind  = K_PAY;
                        res.value = plain;
                    end else begin
                        rx_phase = PH_SKIP;
                        res.kind = K_MALFORMED;
                    end
                    return 1'b1;
                end
                return 1'b0;
            end
            default: begin
                if (req.rx_byte == '0)
                    frame_restart();
                return 1'b0;
            end
        endcase
    endfunction

    task automatic compare_result(input t_crx_result seen);
        t_crx_result want;
        if (due_results.size() == 0) begin
            $error("result with no request outstanding: kind %0d value %0d length %0d",
                   seen.kind, seen.value, seen.pay_len);
            o_fail_count++;
            return;
        end
        want = due_results.pop_front();
        o_checked++;
        case (want.kind)
            K_END:                o_frame_ends++;
            K_BADADDR, K_OVERRUN: o_rejected++;
            K_MALFORMED:          o_malformed++;
            default:              ;
        endcase
        if (seen.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, seen.kind);
            o_fail_count++;
        end
        if (seen.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, seen.value);
            o_fail_count++;
        end
        if (seen.pay_len !== want.pay_len) begin
            $error("pay_len: expected %0d, got %0d",
                   want.pay_len, seen.pay_len);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_crx_result predicted;
        if (!i_rst_n) begin
            frame_restart();
            pay_seen     = 0;
            station_addr = '0;
            due_results.delete();
        end else begin
            // A result popped at this edge cannot stem from a request pushed
            // at the same edge, so the pop side is handled first.
            if (i_pop && !i_empty)
                compare_result(i_result);
            if (i_cfg_we)
                station_addr = i_cfg_wdata;
            if (i_push && !i_full) begin
                if (decode_request(i_rx_item, predicted))
                    due_results.push_back(predicted);
            end
        end
        o_pending = due_results.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench of the COBS packet receiver
// Drives COBS-encoded frames, damaged frames and line noise into the
// receiver under several station addresses, with random gaps on the byte
// side and random stalls on the result side. A checker beside the block
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import crx_pkg::*;

    localparam int DEST_BYTES  = 4;
    localparam int PAYLOAD_MAX = 256;
    localparam int CRC_BYTES   = 2;
    localparam int FRAME_MAX   = PAYLOAD_MAX + CRC_BYTES;

    // How host_holding is driven over the bytes of one frame.
    localparam int HOLD_NEVER  = 0;
    localparam int HOLD_ALWAYS = 1;
    localparam int HOLD_RANDOM = 2;

    localparam int LONG_GAP      = 40;
    localparam int PHASE_BYTES   = 220;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_LIMIT   = 20000;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we;
    logic [ADDR_W-1:0] i_cfg_wdata;
    logic              push;
    t_crx_in           i_rx_item;
    logic              full;
    logic              empty;
    logic              pop = 1'b0;
    t_crx_result       o_result;

    int fail_count;
    int pending;
    int checked;
    int frame_ends;
    int rejected;
    int malformed;

    // Stimulus controls: gaps between byte requests and stalls on the result
    // side can each be switched off to give stretches at full rate.
    bit tx_gaps_on  = 1'b0;
    bit rd_stall_on = 1'b0;
    int rd_left     = 0;

    int bytes_sent     = 0;
    int bursts_sent    = 0;
    int addr_settings  = 0;
    logic [ADDR_W-1:0] station_addr = '0;

    logic [BYTE_W-1:0] plain_q[$];
    logic [BYTE_W-1:0] line_q[$];

    always #5 i_clk = ~i_clk;

    cobs_packet_receiver_top #(
        .DEST_BYTES (DEST_BYTES),
        .PAYLOAD_MAX(PAYLOAD_MAX),
        .CRC_BYTES  (CRC_BYTES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .push       (push),
        .i_rx_item  (i_rx_item),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result)
    );

    crx_checker #(
        .DEST_BYTES (DEST_BYTES),
        .PAYLOAD_MAX(PAYLOAD_MAX),
        .CRC_BYTES  (CRC_BYTES)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_full      (full),
        .i_rx_item   (i_rx_item),
        .i_pop       (pop),
        .i_empty     (empty),
        .i_result    (o_result),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_frame_ends(frame_ends),
        .o_rejected  (rejected),
        .o_malformed (malformed)
    );

    // Gap lengths: mostly none or short ones, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, LONG_GAP);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte(input int zero_pct);
        if ($urandom_range(0, 99) < zero_pct)
            return 8'h00;
        return 8'($urandom_range(1, 255));
    endfunction

    // Addresses with a fair share of zero bytes, so that the destination
    // itself exercises the zero-insertion path of the decoder.
    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [ADDR_W-1:0] a;
        int i;
        a = '0;
        for (i = 0; i < ADDR_BYTES; i++)
            a = a | ({24'd0, rand_byte(30)} << (8 * i));
        return a;
    endfunction

    // The result side toggles pop after random stretches while stalls are
    // enabled; otherwise it accepts a result every cycle in which one is waiting.
    always @(negedge i_clk) begin
        if (!rd_stall_on) begin
            pop     <= 1'b1;
            rd_left <= 0;
        end else if (rd_left > 0) begin
            rd_left <= rd_left - 1;
        end else begin
            pop     <= ~pop;
            rd_left <= pick_gap();
        end
    end

    // One byte request. It is entered at a falling edge and returns at the
    // falling edge after the request was taken, with push still high, so that
    // a following request without a gap never drops push in between.
    task automatic push_line_byte(input logic [BYTE_W-1:0] b, input logic hold);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push                   <= 1'b1;
        i_rx_item.rx_byte      <= b;
        i_rx_item.host_holding <= hold;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_line(input int hold_mode);
        logic hold;
        foreach (line_q[i]) begin
            case (hold_mode)
                HOLD_ALWAYS: hold = 1'b1;
                HOLD_RANDOM: hold = 1'($urandom_range(0, 1));
                default:     hold = 1'b0;
            endcase
            push_line_byte(line_q[i], hold);
        end
        bursts_sent++;
    endtask

    // Builds the plain frame (destination, command, index, payload with its
    // CRC bytes), cuts it to keep bytes when keep is not negative, then
    // COBS-encodes it into line_q with the closing zero delimiter.
    task automatic make_frame(input logic [ADDR_W-1:0] dest, input int npay,
                              input int zero_pct, input int keep);
        int          i;
        int          code_at;
        logic [7:0]  code;
        plain_q.delete();
        for (i = 0; i < DEST_BYTES; i++)
            plain_q.push_back(8'((dest >> (8 * i)) & 32'hFF));
        plain_q.push_back(rand_byte(zero_pct));
        plain_q.push_back(rand_byte(zero_pct));
        for (i = 0; i < npay; i++)
            plain_q.push_back(rand_byte(zero_pct));
        if (keep >= 0)
            while (plain_q.size() > keep)
                void'(plain_q.pop_back());

        line_q.delete();
        code_at = 0;
        code    = 8'd1;
        line_q.push_back(8'h00);
        foreach (plain_q[j]) begin
            if (plain_q[j] == 8'h00) begin
                line_q[code_at] = code;
                code_at         = line_q.size();
                line_q.push_back(8'h00);
                code = 8'd1;
            end else begin
                line_q.push_back(plain_q[j]);
                code = code + 8'd1;
                // A full block of 254 data bytes carries no implied zero.
                if (code == BYTE_MAX) begin
                    line_q[code_at] = code;
                    code_at         = line_q.size();
                    line_q.push_back(8'h00);
                    code = 8'd1;
                end
            end
        end
        line_q[code_at] = code;
        line_q.push_back(8'h00);
    endtask

    // Drops push and waits until every expected result has been popped or the
    // drain limit runs out, then lets the queues settle, since bytes that give
    // no result may still sit in the byte queue.
    task automatic drain_results();
        int n;
        push <= 1'b0;
        n = 0;
        while (pending != 0 && n < DRAIN_LIMIT) begin
            @(negedge i_clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_station_addr(input logic [ADDR_W-1:0] a);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= a;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        station_addr = a;
        addr_settings++;
    endtask

    // One randomly chosen burst: most are well-formed frames for this station,
    // the rest are cut, misaddressed, blocked, damaged frames or plain noise.
    task automatic random_burst();
        int r;
        int npay;
        int zp;
        int n;
        r  = $urandom_range(0, 99);
        zp = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 40);
        if ($urandom_range(0, 99) < 2) begin
            npay = $urandom_range(FRAME_MAX - 6, FRAME_MAX + 3);
            zp   = $urandom_range(0, 1) ? 0 : 2;
        end else begin
            npay = $urandom_range(0, 12);
        end

        if (r < 60) begin
            make_frame(station_addr, npay, zp, -1);
            send_line($urandom_range(0, 9) == 0 ? HOLD_RANDOM : HOLD_NEVER);
        end else if (r < 70) begin
            make_frame(station_addr, npay, zp,
                       $urandom_range(0, DEST_BYTES + 2 + npay - 1));
            send_line(HOLD_NEVER);
        end else if (r < 78) begin
            make_frame(station_addr ^ (32'd1 << $urandom_range(0, ADDR_W - 1)),
                       npay, zp, -1);
            send_line(HOLD_RANDOM);
        end else if (r < 85) begin
            make_frame(station_addr, npay, zp, -1);
            send_line(HOLD_ALWAYS);
        end else if (r < 93) begin
            make_frame(station_addr, npay, zp, -1);
            line_q[$urandom_range(0, line_q.size() - 2)] = 8'($urandom_range(0, 255));
            send_line(HOLD_NEVER);
        end else begin
            line_q.delete();
            n = $urandom_range(1, 12);
            repeat (n)
                line_q.push_back(rand_byte(20));
            send_line(HOLD_RANDOM);
        end
    endtask

    initial begin : stimulus
        int phase_start;
        int k;
        int leftover;
        push        = 1'b0;
        i_rx_item   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        tx_gaps_on  = 1'b1;
        rd_stall_on = 1'b1;

        // Directed part, first under the address left by reset.
        make_frame('0, CRC_BYTES, 0, -1);        // shortest good frame
        send_line(HOLD_NEVER);
        make_frame('0, 0, 0, -1);                // payload shorter than the CRC
        send_line(HOLD_NEVER);
        make_frame('0, CRC_BYTES - 1, 0, -1);
        send_line(HOLD_NEVER);
        make_frame(32'h0403_0201, 3, 0, -1);     // wrong destination
        send_line(HOLD_NEVER);
        make_frame('0, 4, 0, -1);                // host still holds a packet
        send_line(HOLD_ALWAYS);
        make_frame('0, 4, 0, 2);                 // zero inside the destination
        send_line(HOLD_NEVER);
        make_frame('0, 4, 0, DEST_BYTES);        // zero in place of the command
        send_line(HOLD_NEVER);
        make_frame('0, 4, 0, DEST_BYTES + 1);    // zero in place of the index
        send_line(HOLD_NEVER);
        line_q.delete();                         // a lone delimiter
        line_q.push_back(8'h00);
        send_line(HOLD_NEVER);
        make_frame('0, 6, 100, -1);              // all-zero command, index, payload
        send_line(HOLD_NEVER);

        write_station_addr(32'hFFFF_FFFF);
        make_frame(station_addr, FRAME_MAX, 0, -1);     // longest payload
        send_line(HOLD_NEVER);
        make_frame(station_addr, FRAME_MAX + 1, 0, -1); // payload overflow
        send_line(HOLD_NEVER);
        make_frame('0, 2, 0, -1);                       // old address now refused
        send_line(HOLD_NEVER);

        // Random part, one phase per address setting: a random one, the
        // all-zero extreme, one rich in zero bytes and a fixed pattern.
        for (k = 0; k < 4; k++) begin
            case (k)
                0:       write_station_addr($urandom());
                1:       write_station_addr('0);
                2:       write_station_addr(rand_addr());
                default: write_station_addr(32'h00FF_00FF);
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                tx_gaps_on  = $urandom_range(0, 4) != 0;
                rd_stall_on = $urandom_range(0, 4) != 0;
                random_burst();
                // Now and then the sender holds back until all is delivered.
                if ($urandom_range(0, 19) == 0)
                    drain_results();
            end
        end

        rd_stall_on = 1'b1;
        drain_results();
        repeat (20) @(negedge i_clk);

        leftover = pending;
        if (leftover != 0)
            $error("%0d expected results never arrived", leftover);

        $display("Run covered %0d line bytes in %0d frames and noise bursts under %0d addresses.",
                 bytes_sent, bursts_sent, addr_settings + 1);
        $display("Checked %0d results: %0d frame ends, %0d refused, %0d malformed.",
                 checked, frame_ends, rejected, malformed);
        if (fail_count == 0 && leftover == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #(10 * 2_000_000);
        $display("Timeout: the run did not complete.");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
